[rtl/fat_boot_sector_parser_unit_macros.svh]
// assertion macros for the boot sector parser checker
// needs clk and arst_n in the scope that uses them
`ifndef FAT_BOOT_SECTOR_PARSER_UNIT_MACROS_SVH
`define FAT_BOOT_SECTOR_PARSER_UNIT_MACROS_SVH

// same-cycle implication, reset masked
`define FBSP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fbsp check failed");

// next-cycle implication, reset masked
`define FBSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fbsp check failed");

`endif

[rtl/fbsp_pkg.sv]
// shared types, constants and helpers for the boot sector parser
// no dependencies
package fbsp_pkg;

	localparam int SECTOR_BYTES = 512;
	// BPB bytes (25) plus the first signature byte
	localparam int SLOT_COUNT = 26;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int SIG_SLOT = 25;

	localparam logic [31:0] FAT12_LIMIT = 32'd4085;
	localparam logic [31:0] FAT16_LIMIT = 32'd65525;
	localparam logic [23:0] MAX_CLUSTER_BYTES = 24'(32 * 1024);
	localparam logic [7:0] SIG_LO = 8'h55;
	localparam logic [7:0] SIG_HI = 8'haa;

	localparam logic [1:0] FAT_TYPE_12 = 2'd0;
	localparam logic [1:0] FAT_TYPE_16 = 2'd1;
	localparam logic [1:0] FAT_TYPE_32 = 2'd2;
	localparam logic [1:0] FAT_TYPE_NONE = 2'd3;

	// error flag bit positions
	localparam int FLAG_BPS = 0;
	localparam int FLAG_SPC = 1;
	localparam int FLAG_CLUSTER = 2;
	localparam int FLAG_FATS = 3;
	localparam int FLAG_TOTAL = 4;
	localparam int FLAG_FATSZ = 5;
	localparam int FLAG_SIG = 6;
	localparam int FLAG_W = 7;

	typedef struct packed {
		logic [7:0] sector_byte;
		logic       sector_start;
	} sector_item_t;

	typedef struct packed {
		logic [15:0]       bytes_per_sector;
		logic [7:0]        sectors_per_cluster;
		logic [15:0]       reserved_sectors;
		logic [7:0]        fat_count;
		logic [15:0]       root_entries;
		logic [31:0]       total_sectors;
		logic [7:0]        media_code;
		logic [31:0]       fat_sectors;
		logic [31:0]       root_cluster;
		logic [FLAG_W-1:0] error_flags;
		logic [1:0]        fat_type;
	} result_item_t;

	// bit index of a one-hot value (zero gives zero)
	function automatic logic [3:0] onehot_log2(input logic [15:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 16; i++) begin
			if (v[i]) begin
				n = n | 4'(i);
			end
		end
		return n;
	endfunction

endpackage

[rtl/fbsp_if.sv]
// item channels for the boot sector parser: sector bytes in, results out
// depends on fbsp_pkg
interface fbsp_sector_if;
	logic                     valid;
	logic                     ready;
	fbsp_pkg::sector_item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface fbsp_result_if;
	logic                     valid;
	logic                     ready;
	fbsp_pkg::result_item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/fat_boot_sector_parser_unit.sv]
// channel   | dir | payload
// ----------+-----+-------------------------------------------------------
// sector    | in  | sector_byte, sector_start (one byte per item)
// result    | out | BPB fields, error_flags, fat_type (one item per sector)
//
// one sector byte is taken per cycle while sector.ready is high; the result item is
// registered in the cycle after byte SectorBytes-1 is taken.
// BPB bytes sit in capture registers from offset 47 on; a free-running five
// stage pipeline derives the flags and FAT type from them well before the
// signature bytes arrive. reset clears the byte position and the result valid;
// capture and pipeline registers are not reset. sector.ready drops only while
// a result item waits and result.ready is low.
// depends on fbsp_pkg and fbsp_if
module fat_boot_sector_parser_unit #(
	parameter int SectorBytes = fbsp_pkg::SECTOR_BYTES
) (
	input logic          clk,
	input logic          arst_n,
	fbsp_sector_if.sink  sector,
	fbsp_result_if.source result
);

	localparam int PosW = $clog2(SectorBytes);

	logic [PosW-1:0] pos_q;
	logic [PosW-1:0] pos_cur;
	logic            in_acc;
	logic            last_byte;
	logic            slot_hit;
	logic [fbsp_pkg::SLOT_W-1:0] slot_idx;
	logic [7:0]      cap_q [fbsp_pkg::SLOT_COUNT];

	logic [15:0] tot16;
	logic [15:0] fsz16;

	logic [15:0] bps_s1;
	logic [7:0]  spc_s1;
	logic [15:0] rsvd_s1;
	logic [7:0]  nfat_s1;
	logic [15:0] roots_s1;
	logic [31:0] tot_s1;
	logic [31:0] fsz_s1;

	logic [21:0] rds_sum;
	logic [5:0]  flags_s2;
	logic [31:0] fatprod_s2;
	logic [21:0] rds_s2;
	logic [15:0] rsvd_s2;
	logic [31:0] tot_s2;
	logic [2:0]  spc_sh_s2;
	logic        nz_s2;

	logic [31:0] used_s3;
	logic [31:0] tot_s3;
	logic [2:0]  spc_sh_s3;
	logic        ok_s3;

	logic [31:0] clus_s4;
	logic        ok_s4;

	logic [1:0]  type_s5;

	logic        sig_bad;
	logic        res_valid_q;
	fbsp_pkg::result_item_t res_q;

	// handshake
	assign sector.ready = !res_valid_q || result.ready;
	assign in_acc = sector.valid && sector.ready;

	// byte position, restarted by sector_start
	assign pos_cur = sector.payload.sector_start ? '0 : pos_q;
	assign last_byte = pos_cur == PosW'(SectorBytes - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			pos_q <= last_byte ? '0 : pos_cur + PosW'(1);
		end
	end

	// map a byte position to its capture slot
	always_comb begin
		slot_hit = 1'b1;
		slot_idx = '0;
		if (pos_cur >= PosW'(11) && pos_cur <= PosW'(23)) begin
			slot_idx = fbsp_pkg::SLOT_W'(pos_cur - PosW'(11));
		end else if (pos_cur >= PosW'(32) && pos_cur <= PosW'(39)) begin
			slot_idx = fbsp_pkg::SLOT_W'(pos_cur - PosW'(19));
		end else if (pos_cur >= PosW'(44) && pos_cur <= PosW'(47)) begin
			slot_idx = fbsp_pkg::SLOT_W'(pos_cur - PosW'(23));
		end else if (pos_cur == PosW'(SectorBytes - 2)) begin
			slot_idx = fbsp_pkg::SLOT_W'(fbsp_pkg::SIG_SLOT);
		end else begin
			slot_hit = 1'b0;
		end
	end

	// capture registers
	always_ff @(posedge clk) begin
		if (in_acc && slot_hit) begin
			cap_q[slot_idx] <= sector.payload.sector_byte;
		end
	end

	// stage 1: assemble little-endian fields, 16-bit forms fall back to 32-bit
	assign tot16 = {cap_q[9], cap_q[8]};
	assign fsz16 = {cap_q[12], cap_q[11]};

	always_ff @(posedge clk) begin
		bps_s1   <= {cap_q[1], cap_q[0]};
		spc_s1   <= cap_q[2];
		rsvd_s1  <= {cap_q[4], cap_q[3]};
		nfat_s1  <= cap_q[5];
		roots_s1 <= {cap_q[7], cap_q[6]};
		tot_s1   <= (tot16 != 16'd0) ? {16'd0, tot16}
			: {cap_q[16], cap_q[15], cap_q[14], cap_q[13]};
		fsz_s1   <= (fsz16 != 16'd0) ? {16'd0, fsz16}
			: {cap_q[20], cap_q[19], cap_q[18], cap_q[17]};
	end

	// stage 2: validation flags, FAT area size, root directory sectors
	assign rds_sum = 22'({roots_s1, 5'd0}) + 22'(bps_s1) - 22'd1;

	always_ff @(posedge clk) begin
		flags_s2[fbsp_pkg::FLAG_BPS]     <= (bps_s1 & (bps_s1 - 16'd1)) != 16'd0;
		flags_s2[fbsp_pkg::FLAG_SPC]     <= (spc_s1 & (spc_s1 - 8'd1)) != 8'd0;
		flags_s2[fbsp_pkg::FLAG_CLUSTER] <=
			(24'(bps_s1) * 24'(spc_s1)) > fbsp_pkg::MAX_CLUSTER_BYTES;
		flags_s2[fbsp_pkg::FLAG_FATS]    <= nfat_s1 > 8'd2;
		flags_s2[fbsp_pkg::FLAG_TOTAL]   <= tot_s1 == 32'd0;
		flags_s2[fbsp_pkg::FLAG_FATSZ]   <= fsz_s1 == 32'd0;
		fatprod_s2 <= 32'(40'(nfat_s1) * 40'(fsz_s1));
		rds_s2     <= rds_sum >> fbsp_pkg::onehot_log2(bps_s1);
		rsvd_s2    <= rsvd_s1;
		tot_s2     <= tot_s1;
		spc_sh_s2  <= 3'(fbsp_pkg::onehot_log2({8'd0, spc_s1}));
		nz_s2      <= (bps_s1 != 16'd0) && (spc_s1 != 8'd0);
	end

	// stage 3: sectors ahead of the data area
	always_ff @(posedge clk) begin
		used_s3   <= 32'(rsvd_s2) + fatprod_s2 + 32'(rds_s2);
		tot_s3    <= tot_s2;
		spc_sh_s3 <= spc_sh_s2;
		ok_s3     <= nz_s2 && (flags_s2 == 6'd0);
	end

	// stage 4: cluster count, data sectors wrap modulo 2^32
	always_ff @(posedge clk) begin
		clus_s4 <= (tot_s3 - used_s3) >> spc_sh_s3;
		ok_s4   <= ok_s3;
	end

	// stage 5: FAT type from the cluster count
	always_ff @(posedge clk) begin
		if (!ok_s4) begin
			type_s5 <= fbsp_pkg::FAT_TYPE_NONE;
		end else if (clus_s4 < fbsp_pkg::FAT12_LIMIT) begin
			type_s5 <= fbsp_pkg::FAT_TYPE_12;
		end else if (clus_s4 < fbsp_pkg::FAT16_LIMIT) begin
			type_s5 <= fbsp_pkg::FAT_TYPE_16;
		end else begin
			type_s5 <= fbsp_pkg::FAT_TYPE_32;
		end
	end

	// boot signature, last byte checked as it arrives
	assign sig_bad = (cap_q[fbsp_pkg::SIG_SLOT] != fbsp_pkg::SIG_LO)
		|| (sector.payload.sector_byte != fbsp_pkg::SIG_HI);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_acc && last_byte) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_byte) begin
			res_q.bytes_per_sector    <= bps_s1;
			res_q.sectors_per_cluster <= spc_s1;
			res_q.reserved_sectors    <= rsvd_s1;
			res_q.fat_count           <= nfat_s1;
			res_q.root_entries        <= roots_s1;
			res_q.total_sectors       <= tot_s1;
			res_q.media_code          <= cap_q[10];
			res_q.fat_sectors         <= fsz_s1;
			res_q.root_cluster        <= {cap_q[24], cap_q[23], cap_q[22], cap_q[21]};
			res_q.error_flags         <= {sig_bad, flags_s2};
			res_q.fat_type            <= sig_bad ? fbsp_pkg::FAT_TYPE_NONE : type_s5;
		end
	end

	assign result.valid = res_valid_q;
	assign result.payload = res_q;

endmodule

[rtl/fbsp_checker.sv]
// port-level checks for the boot sector parser, bound to the top level
// depends on fbsp_pkg and fat_boot_sector_parser_unit_macros.svh
`include "fat_boot_sector_parser_unit_macros.svh"

module fbsp_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input fbsp_pkg::result_item_t out_payload
);

	logic in_acc;
	logic out_acc;
	logic out_hold;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign out_hold = out_valid && !out_ready;

	// a waiting result item keeps its value
	`FBSP_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_payload))

	// with no result pending the byte stream is never held off
	`FBSP_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

	// a result item is valid only after an accepted byte or while an earlier one is held
	`FBSP_ASSERT_NEXT(a_new_from_input, !out_hold && !in_acc, !out_valid)

	// a determined FAT type only comes with a clean sector
	`FBSP_ASSERT_NOW(a_type_needs_clean, out_valid && out_payload.fat_type != fbsp_pkg::FAT_TYPE_NONE,
		out_payload.error_flags == '0)

	// taken result with no new byte leaves the output empty
	`FBSP_ASSERT_NEXT(a_drain, out_acc && !in_acc, !out_valid)

endmodule

bind fat_boot_sector_parser_unit fbsp_checker u_fbsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sector.valid),
	.in_ready    (sector.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_payload (result.payload)
);

[tb/fat_boot_sector_parser_unit_test.sv]
`timescale 1ns / 1ps
// self-checking bench for the boot sector parser: streams whole and broken sectors
// depends on fbsp_pkg, fbsp_if and fat_boot_sector_parser_unit
module fat_boot_sector_parser_unit_test;

	// boot parameter block as laid out in a sector image
	typedef struct {
		logic [15:0] bps;
		logic [7:0]  spc;
		logic [15:0] rsvd;
		logic [7:0]  nfat;
		logic [15:0] roots;
		logic [15:0] tot16;
		logic [7:0]  media;
		logic [15:0] fsz16;
		logic [31:0] tot32;
		logic [31:0] fsz32;
		logic [31:0] rclus;
		logic [7:0]  sig_lo;
		logic [7:0]  sig_hi;
	} bpb_layout_t;

	// tracks the byte position, predicts each parsed sector and checks it
	class bpb_ledger;
		fbsp_pkg::result_item_t awaited_bpb[$];
		logic [7:0]   seen[fbsp_pkg::SECTOR_BYTES];
		logic [8:0]   offset;
		int           failures;
		int           bytes_taken;
		int           produced;
		int           flagged;
		int           per_type[4];

		function new();
			offset = '0;
			failures = 0;
			bytes_taken = 0;
			produced = 0;
			flagged = 0;
			per_type = '{0, 0, 0, 0};
		endfunction

		// shift amount of a nonzero power of two
		function int unsigned shift_of(logic [31:0] v);
			int unsigned n;
			n = 0;
			while (v > 1 && n < 31) begin
				v = v >> 1;
				n++;
			end
			return n;
		endfunction

		function void take_byte(fbsp_pkg::sector_item_t it);
			logic [8:0]        p;
			fbsp_pkg::result_item_t r;
			logic [31:0]       bps, spc, rsvd, nfat, roots, tot, fsz, rds, used, data, clusters;
			logic [fbsp_pkg::FLAG_W-1:0] flags;
			logic [1:0]        kind;
			bytes_taken++;
			p = it.sector_start ? 9'd0 : offset;
			seen[p] = it.sector_byte;
			if (p != 9'(fbsp_pkg::SECTOR_BYTES - 1)) begin
				offset = p + 9'd1;
				return;
			end
			offset = '0;
			// gather the little-endian fields, with the 32-bit fallbacks
			bps = {seen[12], seen[11]};
			spc = seen[13];
			rsvd = {seen[15], seen[14]};
			nfat = seen[16];
			roots = {seen[18], seen[17]};
			tot = {seen[20], seen[19]};
			if (tot == 0) begin
				tot = {seen[35], seen[34], seen[33], seen[32]};
			end
			fsz = {seen[23], seen[22]};
			if (fsz == 0) begin
				fsz = {seen[39], seen[38], seen[37], seen[36]};
			end
			// validation flags, zero counting as a power of two
			flags = '0;
			flags[fbsp_pkg::FLAG_BPS] = (bps & (bps - 1)) != 0;
			flags[fbsp_pkg::FLAG_SPC] = (spc & (spc - 1)) != 0;
			flags[fbsp_pkg::FLAG_CLUSTER] = bps * spc > 32'd32768;
			flags[fbsp_pkg::FLAG_FATS] = nfat > 2;
			flags[fbsp_pkg::FLAG_TOTAL] = tot == 0;
			flags[fbsp_pkg::FLAG_FATSZ] = fsz == 0;
			flags[fbsp_pkg::FLAG_SIG] =
				seen[fbsp_pkg::SECTOR_BYTES - 2] != fbsp_pkg::SIG_LO
				|| seen[fbsp_pkg::SECTOR_BYTES - 1] != fbsp_pkg::SIG_HI;
			// cluster count decides the type, all sums wrap at 32 bits
			kind = fbsp_pkg::FAT_TYPE_NONE;
			if (flags == 0 && bps != 0 && spc != 0) begin
				rds = (roots * 32 + bps - 1) >> shift_of(bps);
				used = rsvd + nfat * fsz + rds;
				data = tot - used;
				clusters = data >> shift_of(spc);
				if (clusters < fbsp_pkg::FAT12_LIMIT) begin
					kind = fbsp_pkg::FAT_TYPE_12;
				end else if (clusters < fbsp_pkg::FAT16_LIMIT) begin
					kind = fbsp_pkg::FAT_TYPE_16;
				end else begin
					kind = fbsp_pkg::FAT_TYPE_32;
				end
			end
			r.bytes_per_sector = bps[15:0];
			r.sectors_per_cluster = spc[7:0];
			r.reserved_sectors = rsvd[15:0];
			r.fat_count = nfat[7:0];
			r.root_entries = roots[15:0];
			r.total_sectors = tot;
			r.media_code = seen[21];
			r.fat_sectors = fsz;
			r.root_cluster = {seen[47], seen[46], seen[45], seen[44]};
			r.error_flags = flags;
			r.fat_type = kind;
			awaited_bpb.push_back(r);
			produced++;
			per_type[kind]++;
			if (flags != 0) begin
				flagged++;
			end
		endfunction

		function void tally(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
				failures++;
			end
		endfunction

		function void judge_result(fbsp_pkg::result_item_t got);
			fbsp_pkg::result_item_t want;
			if (awaited_bpb.size() == 0) begin
				$display("%0t ns: result item with no sector awaiting it: %p", $time, got);
				failures++;
				return;
			end
			want = awaited_bpb.pop_front();
			tally("bytes_per_sector", want.bytes_per_sector, got.bytes_per_sector);
			tally("sectors_per_cluster", want.sectors_per_cluster, got.sectors_per_cluster);
			tally("reserved_sectors", want.reserved_sectors, got.reserved_sectors);
			tally("fat_count", want.fat_count, got.fat_count);
			tally("root_entries", want.root_entries, got.root_entries);
			tally("total_sectors", want.total_sectors, got.total_sectors);
			tally("media_code", want.media_code, got.media_code);
			tally("fat_sectors", want.fat_sectors, got.fat_sectors);
			tally("root_cluster", want.root_cluster, got.root_cluster);
			tally("error_flags", want.error_flags, got.error_flags);
			tally("fat_type", want.fat_type, got.fat_type);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	logic [7:0] sector_img[fbsp_pkg::SECTOR_BYTES];
	bpb_ledger board;

	fbsp_sector_if sector_ch();
	fbsp_result_if result_ch();

	fat_boot_sector_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.sector(sector_ch),
		.result(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// offer one item and wait for it to be taken
	task automatic offer_byte(input fbsp_pkg::sector_item_t it);
		int gap;
		bit taken;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			sector_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sector_ch.valid <= 1'b1;
		sector_ch.payload <= it;
		do begin
			@(negedge clk);
			taken = sector_ch.ready;
			@(posedge clk);
		end while (!taken);
		board.take_byte(it);
	endtask

	task automatic stream_bytes(input int count, input bit mark);
		fbsp_pkg::sector_item_t it;
		int i;
		for (i = 0; i < count; i++) begin
			it.sector_byte = sector_img[i];
			it.sector_start = (i == 0) ? mark : 1'b0;
			offer_byte(it);
		end
	endtask

	// random filler with the parameter block and signature placed on top
	function automatic void place(input bpb_layout_t f);
		int i;
		for (i = 0; i < fbsp_pkg::SECTOR_BYTES; i++) begin
			sector_img[i] = 8'($urandom);
		end
		{sector_img[12], sector_img[11]} = f.bps;
		sector_img[13] = f.spc;
		{sector_img[15], sector_img[14]} = f.rsvd;
		sector_img[16] = f.nfat;
		{sector_img[18], sector_img[17]} = f.roots;
		{sector_img[20], sector_img[19]} = f.tot16;
		sector_img[21] = f.media;
		{sector_img[23], sector_img[22]} = f.fsz16;
		{sector_img[35], sector_img[34], sector_img[33], sector_img[32]} = f.tot32;
		{sector_img[39], sector_img[38], sector_img[37], sector_img[36]} = f.fsz32;
		{sector_img[47], sector_img[46], sector_img[45], sector_img[44]} = f.rclus;
		sector_img[fbsp_pkg::SECTOR_BYTES - 2] = f.sig_lo;
		sector_img[fbsp_pkg::SECTOR_BYTES - 1] = f.sig_hi;
	endfunction

	// totals that fit in 16 bits go there, junk in the unused 32-bit form
	function automatic bpb_layout_t layout(input logic [15:0] bps, input logic [7:0] spc,
			input logic [15:0] rsvd, input logic [7:0] nfat, input logic [15:0] roots,
			input logic [31:0] tot, input logic [31:0] fsz);
		bpb_layout_t f;
		f.bps = bps;
		f.spc = spc;
		f.rsvd = rsvd;
		f.nfat = nfat;
		f.roots = roots;
		f.tot16 = (tot <= 32'hffff) ? tot[15:0] : 16'd0;
		f.tot32 = (tot <= 32'hffff) ? $urandom : tot;
		f.fsz16 = (fsz <= 32'hffff) ? fsz[15:0] : 16'd0;
		f.fsz32 = (fsz <= 32'hffff) ? $urandom : fsz;
		f.media = 8'hf8;
		f.rclus = 32'd2;
		f.sig_lo = fbsp_pkg::SIG_LO;
		f.sig_hi = fbsp_pkg::SIG_HI;
		return f;
	endfunction

	// well-formed volume aimed at a chosen cluster count
	function automatic bpb_layout_t random_layout();
		bpb_layout_t f;
		int unsigned bsh, csh, fsz, roots, rsvd, nfat, rds, used, clusters, tot;
		bsh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(9, 12);
		csh = $urandom_range(0, (bsh > 8) ? 15 - bsh : 7);
		case ($urandom_range(0, 2))
			0: roots = 0;
			1: roots = 512;
			default: roots = $urandom_range(0, 1024);
		endcase
		case ($urandom_range(0, 3))
			0: clusters = $urandom_range(0, 4084);
			1: clusters = $urandom_range(4085, 65524);
			2: clusters = $urandom_range(65525, 1 << 20);
			default: begin
				case ($urandom_range(0, 3))
					0: clusters = 4084;
					1: clusters = 4085;
					2: clusters = 65524;
					default: clusters = 65525;
				endcase
			end
		endcase
		fsz = $urandom_range(1, 8192);
		nfat = $urandom_range(1, 2);
		rsvd = $urandom_range(1, 64);
		rds = (roots * 32 + (1 << bsh) - 1) >> bsh;
		used = rsvd + nfat * fsz + rds;
		tot = used + (clusters << csh) + $urandom_range(0, (1 << csh) - 1);
		f = layout(16'(1 << bsh), 8'(1 << csh), 16'(rsvd), 8'(nfat), 16'(roots), tot, fsz);
		if ($urandom_range(0, 2) == 0) begin
			f.tot16 = '0;
			f.tot32 = tot;
		end
		if ($urandom_range(0, 2) == 0) begin
			f.fsz16 = '0;
			f.fsz32 = fsz;
		end
		f.media = 8'($urandom);
		f.rclus = $urandom;
		return f;
	endfunction

	task automatic ship(input bpb_layout_t f, input bit mark);
		steady = ($urandom_range(0, 4) == 0);
		place(f);
		stream_bytes(fbsp_pkg::SECTOR_BYTES, mark);
	endtask

	// result side: random stalls, and one long hold-off that backs up the input
	initial begin : result_sink
		int gap;
		bit taken;
		bit held;
		int accepted;
		held = 1'b0;
		accepted = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 3);
			if (accepted == 5 && !held) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = result_ch.valid;
				if (taken) begin
					board.judge_result(result_ch.payload);
				end
				@(posedge clk);
			end while (!taken);
			accepted++;
		end
	end

	initial begin
		bpb_layout_t f;
		int pick;
		int directed_results;
		bit need_mark;
		board = new();
		arst_n = 1'b0;
		sector_ch.valid = 1'b0;
		sector_ch.payload = '0;
		result_ch.ready = 1'b0;
		steady = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain FAT16, then FAT12 streamed on with no start mark
		ship(layout(512, 4, 1, 2, 512, 40000, 64), 1'b1);
		f = layout(512, 1, 1, 2, 224, 2880, 9);
		f.media = 8'hf0;
		ship(f, 1'b0);
		// FAT32 through both 32-bit fallbacks
		f = layout(512, 8, 32, 2, 0, 32'h0020_0000, 2000);
		f.fsz16 = '0;
		f.fsz32 = 2000;
		f.rclus = 32'hffff_ffff;
		ship(f, 1'b1);
		// either side of both type thresholds
		ship(layout(512, 1, 1, 1, 0, 2 + 4084, 1), 1'b1);
		ship(layout(512, 1, 1, 1, 0, 2 + 4085, 1), 1'b0);
		ship(layout(512, 1, 1, 1, 0, 2 + 65524, 1), 1'b1);
		ship(layout(512, 1, 1, 1, 0, 2 + 65525, 1), 1'b1);
		// zero divisors pass the checks but leave the type undetermined
		ship(layout(0, 1, 1, 2, 512, 40000, 64), 1'b1);
		ship(layout(512, 0, 1, 2, 512, 40000, 64), 1'b1);
		// all ones
		f = layout(16'hffff, 8'hff, 16'hffff, 8'hff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
		f.tot16 = 16'hffff;
		f.fsz16 = 16'hffff;
		f.media = 8'hff;
		f.rclus = 32'hffff_ffff;
		f.sig_lo = 8'hff;
		f.sig_hi = 8'hff;
		ship(f, 1'b1);
		// all zero
		f = layout(0, 0, 0, 0, 0, 0, 0);
		f.tot32 = '0;
		f.fsz32 = '0;
		f.media = '0;
		f.rclus = '0;
		f.sig_lo = '0;
		f.sig_hi = '0;
		ship(f, 1'b1);
		// cluster size at the limit, then just over it
		ship(layout(4096, 8, 1, 2, 512, 100000, 100), 1'b1);
		ship(layout(4096, 16, 1, 2, 512, 100000, 100), 1'b1);
		// three FATs, then each half of the signature wrong
		ship(layout(512, 4, 1, 3, 512, 40000, 64), 1'b1);
		f = layout(512, 4, 1, 2, 512, 40000, 64);
		f.sig_hi = 8'hab;
		ship(f, 1'b1);
		f.sig_hi = fbsp_pkg::SIG_HI;
		f.sig_lo = 8'h54;
		ship(f, 1'b1);
		// metadata larger than the volume, and a FAT product that wraps
		ship(layout(512, 1, 16'hffff, 2, 512, 100, 10), 1'b1);
		ship(layout(512, 1, 1, 2, 0, 32'hffff_0000, 32'h8000_0000), 1'b1);
		// restart after part of a sector, down to a single byte
		place(layout(512, 4, 1, 2, 512, 40000, 64));
		stream_bytes(300, 1'b1);
		stream_bytes(1, 1'b1);
		ship(layout(512, 2, 4, 2, 512, 20000, 32), 1'b1);
		directed_results = board.produced;

		// random sectors: mostly well-formed, some damaged, scrambled or cut short
		need_mark = 1'b0;
		while (board.produced < directed_results + 40) begin
			pick = $urandom_range(0, 19);
			if (pick <= 12) begin
				ship(random_layout(), need_mark ? 1'b1 : 1'($urandom));
			end else if (pick <= 14) begin
				f = random_layout();
				case ($urandom_range(0, 5))
					0: f.bps = 16'($urandom);
					1: f.spc = 8'($urandom);
					2: f.nfat = 8'($urandom);
					3: f.roots = 16'($urandom);
					4: begin
						f.tot16 = '0;
						f.tot32 = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
					end
					default: begin
						f.fsz16 = '0;
						f.fsz32 = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
					end
				endcase
				ship(f, need_mark ? 1'b1 : 1'($urandom));
			end else if (pick <= 16) begin
				steady = ($urandom_range(0, 4) == 0);
				place(random_layout());
				for (int i = 0; i < fbsp_pkg::SECTOR_BYTES; i++) begin
					sector_img[i] = 8'($urandom);
				end
				if ($urandom_range(0, 1) == 0) begin
					sector_img[fbsp_pkg::SECTOR_BYTES - 2] = fbsp_pkg::SIG_LO;
					sector_img[fbsp_pkg::SECTOR_BYTES - 1] = fbsp_pkg::SIG_HI;
				end
				stream_bytes(fbsp_pkg::SECTOR_BYTES, 1'b1);
			end else if (pick <= 18) begin
				place(random_layout());
				stream_bytes($urandom_range(1, fbsp_pkg::SECTOR_BYTES - 1), 1'b1);
				need_mark = 1'b1;
				continue;
			end else begin
				f = random_layout();
				f.sig_lo = 8'($urandom);
				f.sig_hi = 8'($urandom);
				ship(f, 1'b1);
			end
			need_mark = 1'b0;
		end
		sector_ch.valid <= 1'b0;

		// drain, then allow for the registered result stage
		while (board.awaited_bpb.size() != 0) @(posedge clk);
		steady = 1'b1;
		repeat (20) @(posedge clk);

		$display("sector bytes taken %0d, boot sectors checked %0d, of which %0d flagged",
			board.bytes_taken, board.produced, board.flagged);
		$display("types seen: fat12 %0d, fat16 %0d, fat32 %0d, undetermined %0d",
			board.per_type[fbsp_pkg::FAT_TYPE_12], board.per_type[fbsp_pkg::FAT_TYPE_16],
			board.per_type[fbsp_pkg::FAT_TYPE_32], board.per_type[fbsp_pkg::FAT_TYPE_NONE]);
		if (board.failures == 0 && board.awaited_bpb.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
